>>> hdl/length_prefixed_jpeg_deframer_assert.svh
// assertion macros used by the deframer core rtl
`ifndef LENGTH_PREFIXED_JPEG_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_JPEG_DEFRAMER_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define LPJD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous active-low reset
`define LPJD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/lpjd_pkg.sv
`default_nettype none

package lpjd_pkg;

    localparam int LEN_W = 18;

    localparam logic [2:0] HDR_BYTES = 3'd4;
    localparam logic [2:0] HDR_LAST  = 3'd3;

    localparam logic [7:0] MARK_FF = 8'hFF;
    localparam logic [7:0] MARK_D8 = 8'hD8;
    localparam logic [7:0] MARK_D9 = 8'hD9;

    localparam logic [LEN_W-1:0] LEN_FLOOR   = 18'd4;
    localparam logic [LEN_W-1:0] LEN_SAT     = 18'h3FFFF;
    localparam logic [LEN_W-1:0] MIN_LEN_RST = 18'd128;
    localparam logic [LEN_W-1:0] MAX_LEN_RST = 18'd131072;

    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_GOOD    = 2'd1;
    localparam logic [1:0] ST_BAD_JPG = 2'd2;
    localparam logic [1:0] ST_BAD_LEN = 2'd3;

    localparam logic CFG_MIN_LENGTH = 1'b0;
    localparam logic CFG_MAX_LENGTH = 1'b1;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_CONN = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             byte_valid;
        logic             frame_end;
        logic [1:0]       status;
        logic [LEN_W-1:0] frame_length;
        logic [31:0]      good_frames;
        logic             halted;
    } t_result;

endpackage

`default_nettype wire

>>> hdl/lpjd_core.sv
`default_nettype none

module lpjd_core import lpjd_pkg::*; #(
    parameter int MAX_FRAME = 131072
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire t_item            i_item,
    input  wire logic [LEN_W-1:0] i_min_len,
    input  wire logic [LEN_W-1:0] i_max_len,
    output t_result               o_res
);

    localparam logic [31:0] LP_MAX = 32'(MAX_FRAME);

    logic [2:0]       r_hdr,   n_hdr;
    logic [31:0]      r_len,   n_len;
    logic [LEN_W-1:0] r_pcnt,  n_pcnt;
    logic             r_sm,    n_sm;
    logic [7:0]       r_prev,  n_prev;
    logic             r_halt,  n_halt;
    logic [31:0]      r_good,  n_good;

    logic [LEN_W-1:0] lo;
    logic [31:0]      asm_len;
    logic             len_ok;
    logic             sm_now;
    logic [LEN_W:0]   pcnt_inc;
    t_result          res;

    assign lo       = (i_min_len < LEN_FLOOR) ? LEN_FLOOR : i_min_len;
    assign asm_len  = {r_len[23:0], i_item.data};
    assign len_ok   = (asm_len >= {14'd0, lo}) && (asm_len <= {14'd0, i_max_len})
                      && (asm_len <= LP_MAX);
    assign pcnt_inc = {1'b0, r_pcnt} + {{LEN_W{1'b0}}, 1'b1};

    always_comb begin
        n_hdr  = r_hdr;
        n_len  = r_len;
        n_pcnt = r_pcnt;
        n_sm   = r_sm;
        n_prev = r_prev;
        n_halt = r_halt;
        n_good = r_good;
        sm_now = r_sm;
        res    = '0;
        if (i_item.func == FUNC_CONN) begin
            n_hdr  = '0;
            n_len  = '0;
            n_pcnt = '0;
            n_sm   = 1'b0;
            n_prev = '0;
            n_halt = 1'b0;
        end else if (r_halt) begin
            n_halt = 1'b1;
        end else if (r_hdr < HDR_BYTES) begin
            n_len = asm_len;
            n_hdr = r_hdr + 3'd1;
            if (r_hdr == HDR_LAST && !len_ok) begin
                n_halt           = 1'b1;
                res.frame_end    = 1'b1;
                res.status       = ST_BAD_LEN;
                res.frame_length = (asm_len > {14'd0, LEN_SAT}) ? LEN_SAT
                                                                : asm_len[LEN_W-1:0];
                n_hdr  = '0;
                n_len  = '0;
                n_pcnt = '0;
                n_sm   = 1'b0;
                n_prev = '0;
            end
        end else begin
            res.out_byte   = i_item.data;
            res.byte_valid = 1'b1;
            if (r_pcnt == '0) begin
                sm_now = (i_item.data == MARK_FF);
            end else if (r_pcnt == {{(LEN_W-1){1'b0}}, 1'b1}) begin
                sm_now = r_sm && (i_item.data == MARK_D8);
            end
            n_sm   = sm_now;
            n_pcnt = pcnt_inc[LEN_W-1:0];
            if (pcnt_inc >= {1'b0, r_len[LEN_W-1:0]}) begin
                res.frame_end    = 1'b1;
                res.frame_length = r_len[LEN_W-1:0];
                if (sm_now && r_prev == MARK_FF && i_item.data == MARK_D9) begin
                    res.status = ST_GOOD;
                    n_good     = r_good + 32'd1;
                end else begin
                    res.status = ST_BAD_JPG;
                end
                n_hdr  = '0;
                n_len  = '0;
                n_pcnt = '0;
                n_sm   = 1'b0;
                n_prev = '0;
            end else begin
                n_prev = i_item.data;
            end
        end
        res.good_frames = n_good;
        res.halted      = n_halt;
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr  <= '0;
            r_len  <= '0;
            r_pcnt <= '0;
            r_sm   <= 1'b0;
            r_prev <= '0;
            r_halt <= 1'b0;
            r_good <= '0;
        end else if (i_step) begin
            r_hdr  <= n_hdr;
            r_len  <= n_len;
            r_pcnt <= n_pcnt;
            r_sm   <= n_sm;
            r_prev <= n_prev;
            r_halt <= n_halt;
            r_good <= n_good;
        end
    end

`include "length_prefixed_jpeg_deframer_assert.svh"

    `LPJD_ASSERT_NOW(a_halt_clears_parser, i_clk, i_rst_n, r_halt, r_hdr == 3'd0 && r_len == 32'd0, "halted with parser state left")
    `LPJD_ASSERT_NOW(a_hdr_range, i_clk, i_rst_n, 1'b1, r_hdr <= HDR_BYTES, "header count out of range")
    `LPJD_ASSERT_NOW(a_payload_len, i_clk, i_rst_n, r_hdr == HDR_BYTES, r_len >= 32'd4 && r_len <= LP_MAX && {14'd0, r_pcnt} < r_len, "payload phase with bad length")
    `LPJD_ASSERT_NEXT(a_good_inc, i_clk, i_rst_n, i_step && res.status == ST_GOOD, r_good == $past(r_good) + 32'd1, "good frame count did not step")

endmodule

`default_nettype wire

>>> hdl/length_prefixed_jpeg_deframer.sv
`default_nettype none

// Length-prefixed JPEG deframer. Each beat on the input channel is a stream byte
// (func 0) or a new-connection event (func 1) and yields exactly one result beat.
// Frames are a 4-byte big-endian length then that many payload bytes; payload
// bytes pass out as they arrive and the last one carries the marker check status.
// A length below 4, below min_length, above max_length or above MAX_FRAME halts
// the stream until the next connection event. Throughput is one beat per clock
// unless the output stalls: the parser state is combinational between the input
// register and the result register, and a stalled output only holds the pipeline
// once both registers are full. Config writes are taken at any time (ready is
// always high) and should only be issued while the block is idle.
module length_prefixed_jpeg_deframer import lpjd_pkg::*; #(
    parameter int MAX_FRAME = 131072
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic             i_func,
    input  wire logic [7:0]       i_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [7:0]            o_out_byte,
    output logic                  o_byte_valid,
    output logic                  o_frame_end,
    output logic [1:0]            o_status,
    output logic [LEN_W-1:0]      o_frame_length,
    output logic [31:0]           o_good_frames,
    output logic                  o_halted,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic             i_cfg_index,
    input  wire logic [LEN_W-1:0] i_cfg_data
);

    logic             r_in_valid;
    t_item            r_item;
    logic             r_out_valid;
    t_result          r_res;
    logic [LEN_W-1:0] r_min_len;
    logic [LEN_W-1:0] r_max_len;

    logic    step;
    t_result core_res;

    assign step        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || step;
    assign o_cfg_ready = 1'b1;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.func <= i_func;
            r_item.data <= i_data;
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= MIN_LEN_RST;
            r_max_len <= MAX_LEN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN_LENGTH: r_min_len <= i_cfg_data;
                CFG_MAX_LENGTH: r_max_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lpjd_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_item    (r_item),
        .i_min_len (r_min_len),
        .i_max_len (r_max_len),
        .o_res     (core_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= core_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_res.out_byte;
    assign o_byte_valid   = r_res.byte_valid;
    assign o_frame_end    = r_res.frame_end;
    assign o_status       = r_res.status;
    assign o_frame_length = r_res.frame_length;
    assign o_good_frames  = r_res.good_frames;
    assign o_halted       = r_res.halted;

endmodule

`default_nettype wire
